// ===== rtl/core/sklp_pkg.sv =====
// Shared types and constants for the string-key linear-probe map.
// No dependencies; used by every other file of the block except sklp_ram.
package sklp_pkg;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned TOTAL_W = 9;
  localparam int unsigned OP_W    = 3;

  localparam logic [31:0] DJB2_SEED = 32'd5381;

  localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
  localparam logic [OP_W-1:0] OP_REPLACE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  typedef struct packed {
    logic in_load;
    logic hash_in;
    logic hash_mv;
    logic idx_clr;
    logic idx_home;
    logic idx_inc;
    logic rd_en;
    logic set_found;
    logic wr_put;
    logic wr_move;
    logic wr_free;
    logic clr_step;
    logic mv_latch;
    logic gap_load;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic res_load;
    logic res_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            key_empty;
    logic            used;
    logic            key_match;
    logic            found;
    logic            home_ready;
    logic            idx_last;
    logic            full;
    logic            stays;
    logic            out_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/sklp_if.sv =====
// Request and response channel interfaces of the map.
// Depends on sklp_pkg for field widths.
interface sklp_req_if;
  logic                        valid;
  logic                        ready;
  logic [sklp_pkg::OP_W-1:0]   op;
  logic [sklp_pkg::KEY_W-1:0]  key;
  logic [sklp_pkg::VAL_W-1:0]  value;
  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface sklp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic                         found;
  logic [sklp_pkg::VAL_W-1:0]   read_value;
  logic [sklp_pkg::TOTAL_W-1:0] entry_total;
  modport source (output valid, ok, found, read_value, entry_total, input ready);
  modport sink   (input valid, ok, found, read_value, entry_total, output ready);
endinterface

// ===== rtl/core/sklp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module sklp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sklp_hash.sv =====
// Byte-serial djb2 hash, then a reciprocal-multiply remainder by the table size when
// that size is not a power of two, else the low hash bits. Depends on sklp_pkg.
module sklp_hash #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [sklp_pkg::KEY_W-1:0]     key,
  output logic                           ready,
  output logic [$clog2(TABLE_SLOTS)-1:0] home
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / TABLE_SLOTS);
  localparam logic [31:0] SLOTS32 = 32'(TABLE_SLOTS);

  logic [sklp_pkg::KEY_W-1:0] hkey;
  logic [31:0]                h;
  logic [2:0]                 bcnt;
  logic [1:0]                 mstep;
  logic [31:0]                q;
  logic [31:0]                r;
  logic                       alive;
  logic                       hashing;
  logic                       modding;
  logic                       done;
  logic [7:0]                 c;
  logic [31:0]                h33;
  logic [63:0]                prod;

  assign c    = hkey[7:0];
  assign h33  = {h[26:0], 5'b0} + h + {24'b0, c};
  assign prod = {32'b0, h} * {32'b0, RECIP};

  // quotient estimate is at most one short, so a single correction follows
  always_ff @(posedge clk) begin
    if (rst) begin
      hashing <= 1'b0;
      modding <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      hkey    <= key;
      h       <= sklp_pkg::DJB2_SEED;
      bcnt    <= '0;
      alive   <= 1'b1;
      hashing <= 1'b1;
      modding <= 1'b0;
      done    <= 1'b0;
    end else if (hashing) begin
      if (alive && c != 8'h00) begin
        h <= h33;
      end else begin
        alive <= 1'b0;
      end
      hkey <= hkey >> 8;
      bcnt <= bcnt + 3'd1;
      if (bcnt == 3'(KEY_BYTES - 1)) begin
        hashing <= 1'b0;
        if (IS_POW2) begin
          done <= 1'b1;
        end else begin
          modding <= 1'b1;
          mstep   <= '0;
        end
      end
    end else if (modding) begin
      mstep <= mstep + 2'd1;
      case (mstep)
        2'd0: begin
          q <= prod[63:32];
        end
        2'd1: begin
          r <= h - q * SLOTS32;
        end
        default: begin
          if (r >= SLOTS32) begin
            r <= r - SLOTS32;
          end
          modding <= 1'b0;
          done    <= 1'b1;
        end
      endcase
    end
  end

  assign ready = done;
  assign home  = IS_POW2 ? h[AW-1:0] : r[AW-1:0];

endmodule

// ===== rtl/core/sklp_datapath.sv =====
// Map datapath: slot RAM, probe and gap indexes, entry count, hash unit, result register.
// Depends on sklp_pkg, sklp_ram and sklp_hash.
module sklp_datapath #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sklp_pkg::dp_cmd_t              cmd,
  output sklp_pkg::dp_status_t           stat,
  input  logic [sklp_pkg::OP_W-1:0]      in_op,
  input  logic [sklp_pkg::KEY_W-1:0]     in_key,
  input  logic [sklp_pkg::VAL_W-1:0]     in_value,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           ok,
  output logic                           found,
  output logic [sklp_pkg::VAL_W-1:0]     read_value,
  output logic [sklp_pkg::TOTAL_W-1:0]   entry_total
);

  localparam int unsigned AW = $clog2(TABLE_SLOTS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned WW = 1 + sklp_pkg::KEY_W + sklp_pkg::VAL_W;

  function automatic logic [sklp_pkg::KEY_W-1:0] norm_key(input logic [sklp_pkg::KEY_W-1:0] raw);
    logic [sklp_pkg::KEY_W-1:0] k;
    logic                       alive;
    k     = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= KEY_BYTES || raw[8*b +: 8] == 8'h00) begin
        alive = 1'b0;
      end
      if (alive) begin
        k[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return k;
  endfunction

  logic [sklp_pkg::OP_W-1:0]  op_q;
  logic [sklp_pkg::KEY_W-1:0] key_q;
  logic [sklp_pkg::VAL_W-1:0] val_q;
  logic [sklp_pkg::KEY_W-1:0] mv_key;
  logic [sklp_pkg::VAL_W-1:0] mv_val;
  logic [sklp_pkg::VAL_W-1:0] found_val;
  logic                       found_q;
  logic [AW-1:0]              idx;
  logic [AW-1:0]              gap;
  logic [CW-1:0]              cnt;
  logic [31:0]                cnt32;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [WW-1:0]              wdata;
  logic [WW-1:0]              rdata;
  logic                       rd_used;
  logic [sklp_pkg::KEY_W-1:0] rd_key;
  logic [sklp_pkg::VAL_W-1:0] rd_val;

  logic                       h_start;
  logic [sklp_pkg::KEY_W-1:0] h_key;
  logic                       h_ready;
  logic [AW-1:0]              home;
  logic                       idx_last;

  assign rd_used  = rdata[WW-1];
  assign rd_key   = rdata[WW-2 -: sklp_pkg::KEY_W];
  assign rd_val   = rdata[sklp_pkg::VAL_W-1:0];
  assign idx_last = idx == AW'(TABLE_SLOTS - 1);
  assign cnt32    = 32'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q  <= in_op;
      key_q <= norm_key(in_key);
      val_q <= in_value;
    end
    if (cmd.set_found) begin
      found_val <= rd_val;
    end
    if (cmd.mv_latch) begin
      mv_key <= rd_key;
      mv_val <= rd_val;
    end
    if (cmd.gap_load || cmd.wr_move) begin
      gap <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      cnt     <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_home) begin
        idx <= home;
      end else if (cmd.idx_inc || cmd.clr_step) begin
        idx <= idx_last ? '0 : idx + AW'(1);
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.in_load) begin
        found_q <= 1'b0;
      end else if (cmd.set_found) begin
        found_q <= rd_used && rd_key == key_q;
      end
    end
  end

  assign we    = cmd.wr_put || cmd.wr_move || cmd.wr_free || cmd.clr_step;
  assign waddr = (cmd.wr_put || cmd.clr_step) ? idx : gap;

  always_comb begin
    if (cmd.wr_put) begin
      wdata = {1'b1, key_q, val_q};
    end else if (cmd.wr_move) begin
      wdata = {1'b1, mv_key, mv_val};
    end else begin
      wdata = '0;
    end
  end

  sklp_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (rdata)
  );

  assign h_start = cmd.hash_in || cmd.hash_mv;
  assign h_key   = cmd.hash_mv ? rd_key : key_q;

  sklp_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (h_start),
    .key   (h_key),
    .ready (h_ready),
    .home  (home)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      ok          <= cmd.res_ok;
      found       <= found_q;
      read_value  <= (cmd.res_ok && op_q == sklp_pkg::OP_GET) ? found_val : '0;
      entry_total <= cnt32[sklp_pkg::TOTAL_W-1:0];
    end
  end

  always_comb begin
    stat.op         = op_q;
    stat.key_empty  = key_q[7:0] == 8'h00;
    stat.used       = rd_used;
    stat.key_match  = rd_key == key_q;
    stat.found      = found_q;
    stat.home_ready = h_ready;
    stat.idx_last   = idx_last;
    stat.full       = {cnt, 1'b0} >= (AW+2)'(TABLE_SLOTS);
    if (gap <= idx) begin
      stat.stays = gap < home && home <= idx;
    end else begin
      stat.stays = gap < home || home <= idx;
    end
    stat.out_busy   = out_valid && !out_ready;
  end

endmodule

// ===== rtl/core/sklp_ctrl.sv =====
// Operation sequencer of the map: probe, update, backward-shift removal, clear pass.
// Depends on sklp_pkg; drives the datapath by command and reads its status.
module sklp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  sklp_pkg::dp_status_t stat,
  output sklp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [13:0] {
    ST_INIT    = 14'b00000000000001,
    ST_IDLE    = 14'b00000000000010,
    ST_DEC     = 14'b00000000000100,
    ST_HASH    = 14'b00000000001000,
    ST_PRB_RD  = 14'b00000000010000,
    ST_PRB_CHK = 14'b00000000100000,
    ST_ACT     = 14'b00000001000000,
    ST_SH_STEP = 14'b00000010000000,
    ST_SH_RD   = 14'b00000100000000,
    ST_SH_CHK  = 14'b00001000000000,
    ST_SH_HASH = 14'b00010000000000,
    ST_SH_DEC  = 14'b00100000000000,
    ST_CLR     = 14'b01000000000000,
    ST_DONE    = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_ok;
  logic   res_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      res_ok <= 1'b0;
    end else begin
      state  <= state_next;
      res_ok <= res_ok_next;
    end
  end

  assign req_ready = state == ST_IDLE;

  always_comb begin
    state_next  = state;
    res_ok_next = res_ok;
    cmd         = '0;
    cmd.res_ok  = res_ok;
    unique case (state)
      ST_INIT: begin
        cmd.clr_step = 1'b1;
        if (stat.idx_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_DEC;
        end
      end
      ST_DEC: begin
        if (stat.op == sklp_pkg::OP_CLEAR) begin
          cmd.idx_clr = 1'b1;
          cmd.cnt_clr = 1'b1;
          res_ok_next = 1'b1;
          state_next  = ST_CLR;
        end else if (stat.op > sklp_pkg::OP_REMOVE || stat.key_empty) begin
          res_ok_next = 1'b0;
          state_next  = ST_DONE;
        end else begin
          cmd.hash_in = 1'b1;
          state_next  = ST_HASH;
        end
      end
      ST_HASH: begin
        if (stat.home_ready) begin
          cmd.idx_home = 1'b1;
          state_next   = ST_PRB_RD;
        end
      end
      ST_PRB_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_PRB_CHK;
      end
      ST_PRB_CHK: begin
        if (!stat.used || stat.key_match) begin
          cmd.set_found = 1'b1;
          state_next    = ST_ACT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_PRB_RD;
        end
      end
      ST_ACT: begin
        state_next = ST_DONE;
        case (stat.op)
          sklp_pkg::OP_PUT: begin
            res_ok_next = !stat.full;
            if (!stat.full) begin
              cmd.wr_put  = 1'b1;
              cmd.cnt_inc = !stat.found;
            end
          end
          sklp_pkg::OP_REPLACE: begin
            res_ok_next = stat.found;
            cmd.wr_put  = stat.found;
          end
          sklp_pkg::OP_GET: begin
            res_ok_next = stat.found;
          end
          sklp_pkg::OP_REMOVE: begin
            res_ok_next = stat.found;
            if (stat.found) begin
              cmd.gap_load = 1'b1;
              cmd.cnt_dec  = 1'b1;
              state_next   = ST_SH_STEP;
            end
          end
          default: begin
            res_ok_next = 1'b0;
          end
        endcase
      end
      ST_SH_STEP: begin
        cmd.idx_inc = 1'b1;
        state_next  = ST_SH_RD;
      end
      ST_SH_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_SH_CHK;
      end
      ST_SH_CHK: begin
        if (!stat.used) begin
          cmd.wr_free = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.mv_latch = 1'b1;
          cmd.hash_mv  = 1'b1;
          state_next   = ST_SH_HASH;
        end
      end
      ST_SH_HASH: begin
        if (stat.home_ready) state_next = ST_SH_DEC;
      end
      ST_SH_DEC: begin
        cmd.wr_move = !stat.stays;
        state_next  = ST_SH_STEP;
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.idx_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/core/string_key_linear_probe_map_top.sv =====
// Top level of the string-key linear-probe map: controller plus datapath.
// Depends on sklp_pkg, sklp_if, sklp_ctrl and sklp_datapath.
//
// Open-addressing key/value map with djb2 home slots and linear probing. One
// operation at a time. After reset, and for every clear, a pass writes each of
// TABLE_SLOTS slots once, one per cycle, with the request side not ready. A
// put, replace, get or remove hashes the key byte by byte (with a remainder
// step when TABLE_SLOTS is not a power of two) and then reads each slot it
// probes through the single RAM read port. A remove then walks the following
// run, rehashing each entry. The result waits in an output register, so a new
// request is taken while the previous response is still pending.
module string_key_linear_probe_map_top #(
  parameter int unsigned TABLE_SLOTS = 256,
  parameter int unsigned KEY_BYTES   = 8
) (
  input logic              clk,
  input logic              rst,
  sklp_req_if.sink         req,
  sklp_rsp_if.source       rsp
);

  sklp_pkg::dp_cmd_t    cmd;
  sklp_pkg::dp_status_t stat;

  sklp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sklp_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (req.op),
    .in_key      (req.key),
    .in_value    (req.value),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .ok          (rsp.ok),
    .found       (rsp.found),
    .read_value  (rsp.read_value),
    .entry_total (rsp.entry_total)
  );

endmodule

// ===== rtl/core/sklp_checker.sv =====
// Port-level checks on the map's request and response transactions.
// Depends on sklp_pkg; bound to string_key_linear_probe_map_top.
module sklp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic                           rsp_ok,
  input logic                           rsp_found,
  input logic [sklp_pkg::VAL_W-1:0]     rsp_read_value,
  input logic [sklp_pkg::TOTAL_W-1:0]   rsp_entry_total
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
      && $stable(rsp_entry_total) && $stable(rsp_ok) && $stable(rsp_found))
    else $error("response changed while stalled");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_read_value != '0 |-> rsp_ok && rsp_found)
    else $error("read value without a successful lookup");

  a_one_at_a_time: assert property (@(posedge clk)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("ready during clearing pass");

endmodule

bind string_key_linear_probe_map_top sklp_checker u_sklp_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_found       (rsp.found),
  .rsp_read_value  (rsp.read_value),
  .rsp_entry_total (rsp.entry_total)
);

// ===== test/string_key_linear_probe_map_top_tb.sv =====
// Self-checking testbench for string_key_linear_probe_map_top: drives map operations
// and checks each response against a behavioural djb2 linear-probe map.
// Depends on sklp_pkg, sklp_if and the block's RTL.
`timescale 1ns / 1ps

module string_key_linear_probe_map_top_tb;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned KBYTES = 8;
  localparam int unsigned N_RANDOM = 1350;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic                          ok;
    logic                          found;
    logic [sklp_pkg::VAL_W-1:0]    read_value;
    logic [sklp_pkg::TOTAL_W-1:0]  entry_total;
  } map_rsp_t;

  class map_scoreboard;
    bit                          used [SLOTS];
    logic [sklp_pkg::KEY_W-1:0]  keys [SLOTS];
    logic [sklp_pkg::VAL_W-1:0]  vals [SLOTS];
    int unsigned                 count;
    map_rsp_t                    pending [$];
    int unsigned                 errors;
    int unsigned                 checked;

    function void clear_all();
      foreach (used[i]) used[i] = 0;
      count = 0;
    endfunction

    function logic [sklp_pkg::KEY_W-1:0] trim_key(logic [sklp_pkg::KEY_W-1:0] raw,
                                                  output logic [31:0] h);
      logic [sklp_pkg::KEY_W-1:0] k;
      logic [7:0] c;
      k = '0;
      h = sklp_pkg::DJB2_SEED;
      for (int b = 0; b < KBYTES; b++) begin
        c = raw[8*b +: 8];
        if (c == 0) break;
        k[8*b +: 8] = c;
        h = h * 33 + c;
      end
      return k;
    endfunction

    function int unsigned home_slot(logic [sklp_pkg::KEY_W-1:0] k);
      logic [31:0] h;
      void'(trim_key(k, h));
      return h % SLOTS;
    endfunction

    function bit locate(logic [sklp_pkg::KEY_W-1:0] k, int unsigned home,
                        output int unsigned slot);
      int unsigned i;
      i = home;
      for (int n = 0; n < SLOTS; n++) begin
        if (!used[i]) begin
          slot = i;
          return 0;
        end
        if (keys[i] == k) begin
          slot = i;
          return 1;
        end
        i = (i + 1) % SLOTS;
      end
      slot = home;
      return 0;
    endfunction

    function void shift_out(int unsigned gap);
      int unsigned j, h;
      bit stays;
      j = gap;
      for (int n = 0; n < SLOTS; n++) begin
        j = (j + 1) % SLOTS;
        if (!used[j] || j == gap) break;
        h = home_slot(keys[j]);
        if (gap <= j) stays = (gap < h && h <= j);
        else stays = (gap < h || h <= j);
        if (!stays) begin
          keys[gap] = keys[j];
          vals[gap] = vals[j];
          gap = j;
        end
      end
      used[gap] = 0;
    endfunction

    function void note_request(logic [sklp_pkg::OP_W-1:0] op, logic [sklp_pkg::KEY_W-1:0] raw,
                               logic [sklp_pkg::VAL_W-1:0] value);
      map_rsp_t r;
      logic [31:0] h;
      logic [sklp_pkg::KEY_W-1:0] k;
      int unsigned slot;
      bit hit;
      r = '0;
      k = trim_key(raw, h);
      if (op == sklp_pkg::OP_CLEAR) begin
        clear_all();
        r.ok = 1;
      end else if (op <= sklp_pkg::OP_REMOVE && k != 0) begin
        hit = locate(k, h % SLOTS, slot);
        r.found = hit;
        case (op)
          sklp_pkg::OP_PUT: begin
            if (count * 2 < SLOTS) begin
              if (hit) begin
                vals[slot] = value;
                r.ok = 1;
              end else if (!used[slot]) begin
                used[slot] = 1;
                keys[slot] = k;
                vals[slot] = value;
                count++;
                r.ok = 1;
              end
            end
          end
          sklp_pkg::OP_REPLACE: begin
            if (hit) begin
              vals[slot] = value;
              r.ok = 1;
            end
          end
          sklp_pkg::OP_GET: begin
            if (hit) begin
              r.read_value = vals[slot];
              r.ok = 1;
            end
          end
          default: begin
            if (hit) begin
              shift_out(slot);
              if (count > 0) count--;
              r.ok = 1;
            end
          end
        endcase
      end
      r.entry_total = count[sklp_pkg::TOTAL_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_response(map_rsp_t got);
      map_rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.ok !== exp.ok)
        $display("%0t: ok expected %0b actual %0b", $time, exp.ok, got.ok);
      if (got.found !== exp.found)
        $display("%0t: found expected %0b actual %0b", $time, exp.found, got.found);
      if (got.read_value !== exp.read_value)
        $display("%0t: read_value expected %h actual %h", $time, exp.read_value,
                 got.read_value);
      if (got.entry_total !== exp.entry_total)
        $display("%0t: entry_total expected %0d actual %0d", $time, exp.entry_total,
                 got.entry_total);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk;
  logic rst;
  sklp_req_if req ();
  sklp_rsp_if rsp ();

  string_key_linear_probe_map_top #(.TABLE_SLOTS(SLOTS), .KEY_BYTES(KBYTES)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  map_scoreboard sb;
  bit quiet;
  longint unsigned cycles;
  logic [sklp_pkg::KEY_W-1:0] key_pool [32];
  int unsigned op_seen [8];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("string_key_linear_probe_map_top_tb failed");
        $finish;
      end
    end
  end

  initial begin
    map_rsp_t got;
    int unsigned stall;
    rsp.ready = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        got = '{rsp.ok, rsp.found, rsp.read_value, rsp.entry_total};
        sb.check_response(got);
      end
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        rsp.ready <= 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 7) - 1;
        rsp.ready <= 0;
      end else begin
        rsp.ready <= 1;
      end
    end
  end

  task automatic send(logic [sklp_pkg::OP_W-1:0] op, logic [sklp_pkg::KEY_W-1:0] key,
                      logic [sklp_pkg::VAL_W-1:0] value);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    req.valid <= 1;
    req.op <= op;
    req.key <= key;
    req.value <= value;
    do @(posedge clk); while (!req.ready);
    sb.note_request(op, key, value);
    op_seen[op]++;
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [sklp_pkg::KEY_W-1:0] make_key();
    logic [sklp_pkg::KEY_W-1:0] k;
    int unsigned len;
    len = $urandom_range(1, 8);
    k = '0;
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    // junk beyond the terminating zero byte
    if (len < 7 && $urandom_range(0, 3) == 0)
      k = k | ({$urandom, $urandom} & ~((64'd1 << (8 * (len + 1))) - 64'd1));
    return k;
  endfunction

  function automatic logic [sklp_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 31)];
    return make_key();
  endfunction

  initial begin
    logic [sklp_pkg::OP_W-1:0] op;
    int unsigned r;
    sb = new();
    sb.clear_all();
    quiet = 0;
    rst = 1;
    req.valid = 0;
    req.op = '0;
    req.key = '0;
    req.value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (key_pool[i]) key_pool[i] = make_key();
    key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[1] = 64'h0000_0000_0000_0061;

    // directed
    send(sklp_pkg::OP_GET, 64'h61, '0);
    send(sklp_pkg::OP_PUT, 64'h61, 64'hFFFF_FFFF_FFFF_FFFF);
    send(sklp_pkg::OP_PUT, 64'hFF00_0061, 64'h1);
    send(sklp_pkg::OP_GET, 64'h61, '0);
    send(sklp_pkg::OP_PUT, '1, '0);
    send(sklp_pkg::OP_GET, '1, '1);
    send(sklp_pkg::OP_REPLACE, '1, 64'h5555_AAAA_5555_AAAA);
    send(sklp_pkg::OP_REPLACE, 64'h62, 64'h7);
    send(sklp_pkg::OP_GET, '1, '0);
    send(sklp_pkg::OP_PUT, 64'hFF00, 64'h3);
    send(sklp_pkg::OP_GET, '0, '0);
    send(sklp_pkg::OP_REMOVE, 64'h1100, '0);
    send(sklp_pkg::OP_REMOVE, 64'h61, '0);
    send(sklp_pkg::OP_REMOVE, 64'h61, '0);
    send(3'd5, 64'h61, '1);
    send(3'd6, '1, '1);
    send(3'd7, '1, '1);
    send(sklp_pkg::OP_CLEAR, '1, '1);
    send(sklp_pkg::OP_GET, '1, '0);
    // fill past the load limit, then remove or look up entries slot by slot through the runs
    for (int i = 0; i < 140; i++)
      send(sklp_pkg::OP_PUT, {$urandom, $urandom} | 64'h1, {$urandom, $urandom});
    send(sklp_pkg::OP_PUT, key_pool[1], '1);
    drain();
    for (int i = 0; i < SLOTS; i++)
      if (sb.used[i])
        send($urandom_range(0, 1) ? sklp_pkg::OP_REMOVE : sklp_pkg::OP_GET, sb.keys[i], '0);
    send(sklp_pkg::OP_CLEAR, '0, '0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      if (i == N_RANDOM - 200) quiet = 1;
      r = $urandom_range(0, 99);
      if (r < 35) op = sklp_pkg::OP_PUT;
      else if (r < 48) op = sklp_pkg::OP_REPLACE;
      else if (r < 72) op = sklp_pkg::OP_GET;
      else if (r < 94) op = sklp_pkg::OP_REMOVE;
      else if (r < 96) op = sklp_pkg::OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      if (r >= 94 && r < 95) send(op, pick_key(), {$urandom, $urandom});
      else if ($urandom_range(0, 40) == 0) send(op, {$urandom, $urandom} & ~64'hFF, '1);
      else send(op, pick_key(), {$urandom, $urandom});
      if ($urandom_range(0, 150) == 0) foreach (key_pool[j]) key_pool[j] = make_key();
    end

    drain();
    repeat (600) @(posedge clk);
    $display("ran %0d checked responses: put %0d replace %0d get %0d remove %0d clear %0d",
             sb.checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("including empty keys, unused op codes, full-table refusals and run shifts");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("string_key_linear_probe_map_top_tb passed");
    end else begin
      $display("string_key_linear_probe_map_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sklp_pkg.sv
rtl/core/sklp_if.sv
rtl/core/sklp_ram.sv
rtl/core/sklp_hash.sv
rtl/core/sklp_datapath.sv
rtl/core/sklp_ctrl.sv
rtl/core/string_key_linear_probe_map_top.sv
rtl/core/sklp_checker.sv
test/string_key_linear_probe_map_top_tb.sv
